>>> hw/rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

  // Bits per occupancy word
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;

  // Operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W         = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 1'b1;

  // Reset value of the page limit register
  localparam logic [10:0] ALLOWED_RST = 11'd1024;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NULL = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  // Request transaction
  typedef struct packed {
    logic        operation;
    logic [63:0] page_address;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic        granted;
    logic [63:0] result_address;
    logic [9:0]  result_index;
    logic [10:0] used_pages;
    status_e     status;
  } rsp_t;

  // Outcome of examining one occupancy word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
    logic             last;
  } scan_t;

endpackage

>>> hw/rtl/bitmap_page_allocator_core.sv
// Bitmap first-fit page allocator: occupancy memory, word-scan sequencer and result register.
// Acquire: scans the words in order (one occupancy word read per cycle), then S_ADDR forms the
//   address and raises the result strobe; when full, the strobe comes straight from the scan.
// Release: subtract, word read, check and write back; refusals at the address check end after
//   the subtract step. busy drops in the strobe cycle, so a new start may coincide with it.
// Reset: asynchronous, active low; the map reads all free through per-word valid bits at once.
// The result strobe lasts one cycle; the receiver cannot stall. PAGE_BYTES and MAX_PAGES
// are powers of two.
module bitmap_page_allocator_core #(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bpa_pkg::req_t                     req_i,
  output logic                              result_valid_o,
  output bpa_pkg::rsp_t                     rsp_o,
  input  logic                              cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [63:0]                       cfg_wdata_i
);

  localparam int unsigned WORDS    = MAX_PAGES / bpa_pkg::WORD_BITS;
  localparam int unsigned WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IDX_W    = $clog2(MAX_PAGES);
  localparam int unsigned LIM_W    = IDX_W + 1;
  localparam int unsigned PG_SHIFT = $clog2(PAGE_BYTES);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_ADDR    = 6'b000100,
    S_REL_SUB = 6'b001000,
    S_REL_RD  = 6'b010000,
    S_REL_CHK = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [10:0] allowed_q;
  logic [63:0] base_q;

  // Transaction registers
  logic [63:0]        addr_q, addr_d;
  logic [LIM_W-1:0]   limit_q, limit_d;
  logic [WORD_AW-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [10:0]        used_q, used_d;

  // Result register
  logic          rvld_q, rvld_d;
  bpa_pkg::rsp_t rsp_q, rsp_d;

  // Occupancy memory
  logic [bpa_pkg::WORD_BITS-1:0] mem_q [WORDS];
  logic [WORDS-1:0]              wvld_q;
  logic [bpa_pkg::WORD_BITS-1:0] rd_data_q;
  logic                          rd_vld_q;
  logic [WORD_AW-1:0]            rd_addr;
  logic                          mem_we;
  logic [WORD_AW-1:0]            mem_waddr;
  logic [bpa_pkg::WORD_BITS-1:0] mem_wdata;
  logic [bpa_pkg::WORD_BITS-1:0] word;

  logic [64:0]         diff;
  logic [IDX_W-1:0]    hit_idx;
  logic [WORD_AW-1:0]  rel_word;
  logic [bpa_pkg::BIT_W-1:0] rel_bit;
  logic [LIM_W-1:0]    limit_now;
  bpa_pkg::scan_t      scan;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rvld_q;
  assign rsp_o          = rsp_q;

  // Never-written words read as free
  assign word = rd_vld_q ? rd_data_q : '0;

  bpa_word_scan #(
    .WORDS   (WORDS),
    .WORD_AW (WORD_AW),
    .LIM_W   (LIM_W)
  ) u_scan (
    .word_i     (word),
    .word_idx_i (ptr_q),
    .limit_i    (limit_q),
    .scan_o     (scan)
  );

  assign diff     = {1'b0, addr_q} - {1'b0, base_q};
  assign hit_idx  = IDX_W'({ptr_q, scan.bit_idx});
  assign rel_word = WORD_AW'(idx_q >> bpa_pkg::BIT_W);
  assign rel_bit  = idx_q[bpa_pkg::BIT_W-1:0];

  // Page limit clipped to the map size
  always_comb begin
    if (32'(allowed_q) > 32'(MAX_PAGES)) begin
      limit_now = LIM_W'(MAX_PAGES);
    end else begin
      limit_now = LIM_W'(allowed_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    limit_d   = limit_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    used_d    = used_q;
    rvld_d    = 1'b0;
    rsp_d     = rsp_q;
    rd_addr   = ptr_q + WORD_AW'(1);
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = word;

    case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        if (start) begin
          addr_d  = req_i.page_address;
          limit_d = limit_now;
          ptr_d   = '0;
          state_d = (req_i.operation == bpa_pkg::OP_RELEASE) ? S_REL_SUB : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.found) begin
          mem_we    = 1'b1;
          mem_wdata = word | ({{(bpa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << scan.bit_idx);
          idx_d     = hit_idx;
          used_d    = used_q + 11'd1;
          state_d   = S_ADDR;
        end else if (scan.last) begin
          rsp_d.granted        = 1'b0;
          rsp_d.result_address = '0;
          rsp_d.result_index   = '0;
          rsp_d.used_pages     = used_q;
          rsp_d.status         = bpa_pkg::ST_FULL;
          rvld_d               = 1'b1;
          state_d              = S_IDLE;
        end else begin
          ptr_d = ptr_q + WORD_AW'(1);
        end
      end
      S_ADDR: begin
        rsp_d.granted        = 1'b1;
        rsp_d.result_address = base_q + (64'(idx_q) << PG_SHIFT);
        rsp_d.result_index   = 10'(idx_q);
        rsp_d.used_pages     = used_q;
        rsp_d.status         = bpa_pkg::ST_OK;
        rvld_d               = 1'b1;
        state_d              = S_IDLE;
      end
      S_REL_SUB: begin
        rsp_d.granted        = 1'b0;
        rsp_d.result_address = '0;
        rsp_d.result_index   = '0;
        rsp_d.used_pages     = used_q;
        if (addr_q == '0) begin
          rsp_d.status = bpa_pkg::ST_NULL;
          rvld_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (diff[64] || ((diff[63:0] >> (PG_SHIFT + IDX_W)) != 64'd0)) begin
          rsp_d.status = bpa_pkg::ST_BAD;
          rvld_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d   = IDX_W'(diff[63:0] >> PG_SHIFT);
          state_d = S_REL_RD;
        end
      end
      S_REL_RD: begin
        rd_addr = rel_word;
        state_d = S_REL_CHK;
      end
      S_REL_CHK: begin
        rsp_d.result_address = '0;
        rvld_d               = 1'b1;
        state_d              = S_IDLE;
        if (word[rel_bit]) begin
          mem_we               = 1'b1;
          mem_waddr            = rel_word;
          mem_wdata            = word & ~({{(bpa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << rel_bit);
          used_d               = used_q - 11'd1;
          rsp_d.granted        = 1'b1;
          rsp_d.result_index   = 10'(idx_q);
          rsp_d.used_pages     = used_q - 11'd1;
          rsp_d.status         = bpa_pkg::ST_OK;
        end else begin
          rsp_d.granted        = 1'b0;
          rsp_d.result_index   = '0;
          rsp_d.used_pages     = used_q;
          rsp_d.status         = bpa_pkg::ST_BAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      rvld_q    <= 1'b0;
      allowed_q <= bpa_pkg::ALLOWED_RST;
      base_q    <= '0;
      wvld_q    <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      rvld_q   <= rvld_d;
      rd_vld_q <= wvld_q[rd_addr];
      if (mem_we) begin
        wvld_q[mem_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bpa_pkg::CFG_ALLOWED_PAGES: allowed_q <= cfg_wdata_i[10:0];
          bpa_pkg::CFG_REGION_BASE:   base_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    limit_q <= limit_d;
    ptr_q   <= ptr_d;
    idx_q   <= idx_d;
    rsp_q   <= rsp_d;
  end

  // Occupancy memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(MAX_PAGES))
    else $error("used page count exceeds map size");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.granted) |-> (rsp_o.status == bpa_pkg::ST_OK))
    else $error("granted result without ok status");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
`endif

endmodule

>>> hw/rtl/bpa_word_scan.sv
// Find-first-free unit: masks one occupancy word by the page limit and finds its lowest free bit.
module bpa_word_scan #(
  parameter int unsigned WORDS   = 16,
  parameter int unsigned WORD_AW = 4,
  parameter int unsigned LIM_W   = 11
) (
  input  logic [bpa_pkg::WORD_BITS-1:0] word_i,
  input  logic [WORD_AW-1:0]            word_idx_i,
  input  logic [LIM_W-1:0]              limit_i,
  output bpa_pkg::scan_t                scan_o
);

  localparam int unsigned HI_W = LIM_W - bpa_pkg::BIT_W;

  logic [HI_W-1:0]                 lim_hi;
  logic [bpa_pkg::BIT_W-1:0]       lim_lo;
  logic [HI_W-1:0]                 w_cur;
  logic [HI_W-1:0]                 w_nxt;
  logic [bpa_pkg::WORD_BITS-1:0]   mask;
  logic [bpa_pkg::WORD_BITS-1:0]   free;
  logic [bpa_pkg::BIT_W-1:0]       first;

  assign lim_hi = limit_i[LIM_W-1:bpa_pkg::BIT_W];
  assign lim_lo = limit_i[bpa_pkg::BIT_W-1:0];
  assign w_cur  = HI_W'(word_idx_i);
  assign w_nxt  = w_cur + HI_W'(1);

  // Pages at or above the limit count as taken
  always_comb begin
    if (lim_hi > w_cur) begin
      mask = '1;
    end else if (lim_hi == w_cur) begin
      mask = ~({bpa_pkg::WORD_BITS{1'b1}} << lim_lo);
    end else begin
      mask = '0;
    end
  end

  assign free = ~word_i & mask;

  // Priority encoder, lowest free bit wins
  always_comb begin
    first = '0;
    for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free[i]) begin
        first = bpa_pkg::BIT_W'(i);
      end
    end
  end

  assign scan_o.found   = |free;
  assign scan_o.bit_idx = first;
  // No usable page lies beyond this word
  assign scan_o.last    = (word_idx_i == WORD_AW'(WORDS - 1)) ||
                          !((lim_hi > w_nxt) ||
                            ((lim_hi == w_nxt) && (lim_lo != '0)));

endmodule
